// ===== sv/psp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psp_pkg
// Shared types, header constants and the sequencer control store for the
// program stream packetizer.
// ----------------------------------------------------------------------------
package psp_pkg;

    // Item kinds carried in s_tuser[1:0]
    typedef enum logic [1:0] {
        OP_FRAME = 2'd0,
        OP_NAL   = 2'd1,
        OP_BYTE  = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    // Register indexes on the config port
    localparam logic [1:0] CFG_MUX_RATE   = 2'd0;
    localparam logic [1:0] CFG_RATE_BOUND = 2'd1;
    localparam logic [1:0] CFG_VIDEO_ID   = 2'd2;

    localparam logic [21:0] MUX_RATE_RST   = 22'd255;
    localparam logic [21:0] RATE_BOUND_RST = 22'd50000;
    localparam logic [7:0]  VIDEO_ID_RST   = 8'd224;

    // Header sizes in bytes; every header is left-aligned in a 192-bit word
    localparam int PACK_BYTES = 14;
    localparam int SYS_BYTES  = 18;
    localparam int MAP_BYTES  = 24;
    localparam int PES_BYTES  = 19;
    localparam int HDR_BITS   = 8 * MAP_BYTES;

    // Stream map is fully constant, CRC included
    localparam logic [HDR_BITS-1:0] MAP_HDR = {
        24'h000001, 8'hBC, 16'd18, 1'b1, 2'b11, 5'd0, 7'h7F, 1'b1,
        16'd0, 16'd8, 8'h90, 8'hC0, 16'd0, 8'h1B, 8'hE0, 16'd0,
        8'h45, 8'hBD, 8'hDC, 8'hF4
    };

    // SCR extension: base mod 100, one nibble per cycle
    localparam int MOD_DIGITS = 9;
    localparam int MOD_BITS   = 4 * MOD_DIGITS;

    // Byte sources of the datapath
    typedef enum logic [2:0] {
        SRC_DATA = 3'd0,
        SRC_PACK = 3'd1,
        SRC_SYS  = 3'd2,
        SRC_MAP  = 3'd3,
        SRC_PES  = 3'd4
    } src_t;

    // Sequencing after the current step
    typedef enum logic [1:0] {
        SEQ_NEXT           = 2'd0,
        SEQ_END            = 2'd1,
        SEQ_END_IF_NOT_KEY = 2'd2
    } seq_t;

    typedef struct packed {
        src_t       src;
        logic [4:0] idx;       // byte of the selected header
        seq_t       seq;
        logic       wait_mod;  // hold until SCR extension is ready
    } ctl_word_t;

    // Program layout
    localparam logic [6:0] STEP_DATA = 7'd0;
    localparam logic [6:0] STEP_PACK = 7'd1;
    localparam logic [6:0] STEP_SYS  = STEP_PACK + 7'(PACK_BYTES);
    localparam logic [6:0] STEP_MAP  = STEP_SYS + 7'(SYS_BYTES);
    localparam logic [6:0] STEP_PES  = STEP_MAP + 7'(MAP_BYTES);
    localparam logic [6:0] STEP_LAST = STEP_PES + 7'(PES_BYTES) - 7'd1;

    // Control store
    function automatic ctl_word_t psp_rom(input logic [6:0] step);
        ctl_word_t cw;
        cw.src      = SRC_DATA;
        cw.idx      = 5'd0;
        cw.seq      = SEQ_END;
        cw.wait_mod = 1'b0;
        if (step == STEP_DATA) begin
            cw.src = SRC_DATA;
        end else if (step < STEP_SYS) begin
            cw.src      = SRC_PACK;
            cw.idx      = 5'(step - STEP_PACK);
            cw.seq      = (step == STEP_SYS - 7'd1) ? SEQ_END_IF_NOT_KEY : SEQ_NEXT;
            cw.wait_mod = (step == STEP_PACK + 7'd8);
        end else if (step < STEP_MAP) begin
            cw.src = SRC_SYS;
            cw.idx = 5'(step - STEP_SYS);
            cw.seq = SEQ_NEXT;
        end else if (step < STEP_PES) begin
            cw.src = SRC_MAP;
            cw.idx = 5'(step - STEP_MAP);
            cw.seq = (step == STEP_PES - 7'd1) ? SEQ_END : SEQ_NEXT;
        end else if (step <= STEP_LAST) begin
            cw.src = SRC_PES;
            cw.idx = 5'(step - STEP_PES);
            cw.seq = (step == STEP_LAST) ? SEQ_END : SEQ_NEXT;
        end
        return cw;
    endfunction

    // 33-bit time stamp with marker bits, as in PES headers
    function automatic logic [39:0] pes_time(input logic [3:0] prefix,
                                             input logic [32:0] t);
        return {prefix, t[32:30], 1'b1, t[29:15], 1'b1, t[14:0], 1'b1};
    endfunction

endpackage

// ===== sv/program_stream_packetizer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// program_stream_packetizer
// Wraps H.264 NAL units into an MPEG-2 program stream, one byte per beat.
// ----------------------------------------------------------------------------
// Usage:
//  - s_ channel: one item per beat. s_tuser[1:0] is the kind (frame start,
//    NAL start, payload byte, the fourth code is dropped), s_tuser[2] marks a
//    key frame. A frame start latches pts/dts and sends a 14-byte pack header,
//    plus an 18-byte system header and a 24-byte stream map on key frames.
//    A NAL start sends a 19-byte PES header using the latched times.
//  - m_ channel: stream bytes, m_tlast on the final byte of each item.
//  - cfg_ channel: register writes, always ready; write only while idle.
// Timing:
//  - The accepting edge loads the sequencer; the first byte then goes into
//    the output register, then one byte per cycle while m_tready allows,
//    set by the single output register and the one-byte-per-step sequencer.
//    Frame starts may wait before byte 9 for the nibble-serial SCR mod 100
//    unit.
//  - A new item is taken on the edge that loads the previous item's last
//    byte, so payload bytes stream at one per cycle while m_tready is high.
// Reset: sequencer idle, output empty, times zero, registers at defaults.
// Stall: with m_tready low the current byte holds and the program waits.
// ----------------------------------------------------------------------------
module program_stream_packetizer
    import psp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // input items
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,   // pts[32:0], dts[65:33], nalu_length[81:66],
                                   // data_byte[89:82], zero fill
    input  logic [2:0]  s_tuser,   // opcode[1:0], is_key_frame[2]
    // stream bytes
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // out_byte[7:0]
    output logic        m_tlast,
    // register writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [21:0] cfg_data
);

    // Input field views
    logic [32:0] s_pts;
    logic [32:0] s_dts;
    logic [15:0] s_nalu_length;
    logic [7:0]  s_data_byte;
    op_t         s_opcode;
    logic        s_key;

    assign s_pts         = s_tdata[32:0];
    assign s_dts         = s_tdata[65:33];
    assign s_nalu_length = s_tdata[81:66];
    assign s_data_byte   = s_tdata[89:82];
    assign s_opcode      = op_t'(s_tuser[1:0]);
    assign s_key         = s_tuser[2];

    // Registers
    logic [21:0]         mux_rate_reg,   mux_rate_next;
    logic [21:0]         rate_bound_reg, rate_bound_next;
    logic [7:0]          video_id_reg,   video_id_next;
    logic [32:0]         frame_pts_reg,  frame_pts_next;
    logic [32:0]         frame_dts_reg,  frame_dts_next;
    logic                busy_reg,       busy_next;
    logic [6:0]          step_reg,       step_next;
    logic                key_reg,        key_next;
    logic [15:0]         nalu_reg,       nalu_next;
    logic [7:0]          data_reg,       data_next;
    logic [MOD_BITS-1:0] mod_sh_reg,     mod_sh_next;
    logic [6:0]          mod_rem_reg,    mod_rem_next;
    logic [3:0]          mod_cnt_reg,    mod_cnt_next;
    logic                m_tvalid_reg,   m_tvalid_next;
    logic [7:0]          m_tdata_reg,    m_tdata_next;
    logic                m_tlast_reg,    m_tlast_next;

    ctl_word_t cw;
    logic      fire;
    logic      s_acc;
    logic      end_bit;
    logic [7:0] out_sel;
    logic [10:0] mod_t;

    logic [HDR_BITS-1:0] hdr_vec;
    logic [8*PACK_BYTES-1:0] pack_hdr;
    logic [8*SYS_BYTES-1:0]  sys_hdr;
    logic [8*PES_BYTES-1:0]  pes_hdr;
    logic [7:0]              shamt;

    assign cw = psp_rom(step_reg);

    // One byte per step when the output register is free and no SCR wait holds
    assign fire = busy_reg && (!m_tvalid_reg || m_tready) &&
                  !(cw.wait_mod && (mod_cnt_reg != 4'd0));
    assign end_bit = (cw.seq == SEQ_END) || ((cw.seq == SEQ_END_IF_NOT_KEY) && !key_reg);

    assign s_tready  = !busy_reg || (fire && end_bit);
    assign s_acc     = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    // Header words, MSB first
    assign pack_hdr = {32'h000001BA, 2'b01, frame_pts_reg[32:30], 1'b1,
                       frame_pts_reg[29:15], 1'b1, frame_pts_reg[14:0], 1'b1,
                       {2'b00, mod_rem_reg}, 1'b1, mux_rate_reg, 2'b11, 5'h1F, 3'b000};
    assign sys_hdr  = {32'h000001BB, 16'd12, 1'b1, rate_bound_reg, 1'b1, 6'd1,
                       1'b0, 4'b1111, 5'd1, 1'b0, 7'h7F,
                       8'hC0, 2'b11, 1'b0, 13'd512,
                       8'hE0, 2'b11, 1'b1, 13'd2048};
    assign pes_hdr  = {24'h000001, video_id_reg, nalu_reg + 16'd13,
                       2'b10, 6'd0, 2'b11, 6'd0, 8'd10,
                       pes_time(4'd3, frame_pts_reg), pes_time(4'd1, frame_dts_reg)};

    always_comb begin
        case (cw.src)
            SRC_PACK: hdr_vec = {pack_hdr, {(HDR_BITS - 8*PACK_BYTES){1'b0}}};
            SRC_SYS:  hdr_vec = {sys_hdr,  {(HDR_BITS - 8*SYS_BYTES){1'b0}}};
            SRC_MAP:  hdr_vec = MAP_HDR;
            SRC_PES:  hdr_vec = {pes_hdr,  {(HDR_BITS - 8*PES_BYTES){1'b0}}};
            default:  hdr_vec = '0;
        endcase
        shamt   = {5'(MAP_BYTES - 1) - cw.idx, 3'b000};
        out_sel = (cw.src == SRC_DATA) ? data_reg : 8'(hdr_vec >> shamt);
    end

    // Nibble step of base mod 100: r = (16r + d) mod 100, r*16+15 < 1600
    always_comb begin
        mod_t = {mod_rem_reg, 4'b0000} + 11'(mod_sh_reg[MOD_BITS-1 -: 4]);
        if (mod_t >= 11'd800) mod_t = mod_t - 11'd800;
        if (mod_t >= 11'd400) mod_t = mod_t - 11'd400;
        if (mod_t >= 11'd200) mod_t = mod_t - 11'd200;
        if (mod_t >= 11'd100) mod_t = mod_t - 11'd100;
    end

    always_comb begin
        mux_rate_next   = mux_rate_reg;
        rate_bound_next = rate_bound_reg;
        video_id_next   = video_id_reg;
        frame_pts_next  = frame_pts_reg;
        frame_dts_next  = frame_dts_reg;
        busy_next       = busy_reg;
        step_next       = step_reg;
        key_next        = key_reg;
        nalu_next       = nalu_reg;
        data_next       = data_reg;
        mod_sh_next     = mod_sh_reg;
        mod_rem_next    = mod_rem_reg;
        mod_cnt_next    = mod_cnt_reg;
        m_tvalid_next   = m_tvalid_reg;
        m_tdata_next    = m_tdata_reg;
        m_tlast_next    = m_tlast_reg;

        if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_MUX_RATE:   mux_rate_next   = cfg_data;
                CFG_RATE_BOUND: rate_bound_next = cfg_data;
                CFG_VIDEO_ID:   video_id_next   = cfg_data[7:0];
                default: ;
            endcase
        end

        if (mod_cnt_reg != 4'd0) begin
            mod_rem_next = mod_t[6:0];
            mod_sh_next  = {mod_sh_reg[MOD_BITS-5:0], 4'b0000};
            mod_cnt_next = mod_cnt_reg - 4'd1;
        end

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        if (fire) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = out_sel;
            m_tlast_next  = end_bit;
            step_next     = step_reg + 7'd1;
            if (end_bit) begin
                busy_next = 1'b0;
            end
        end

        if (s_acc) begin
            key_next  = s_key;
            nalu_next = s_nalu_length;
            data_next = s_data_byte;
            case (s_opcode)
                OP_FRAME: begin
                    frame_pts_next = s_pts;
                    frame_dts_next = s_dts;
                    mod_sh_next    = {{(MOD_BITS - 33){1'b0}}, s_pts};
                    mod_rem_next   = 7'd0;
                    mod_cnt_next   = 4'(MOD_DIGITS);
                    busy_next      = 1'b1;
                    step_next      = STEP_PACK;
                end
                OP_NAL: begin
                    busy_next = 1'b1;
                    step_next = STEP_PES;
                end
                OP_BYTE: begin
                    busy_next = 1'b1;
                    step_next = STEP_DATA;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mux_rate_reg   <= MUX_RATE_RST;
            rate_bound_reg <= RATE_BOUND_RST;
            video_id_reg   <= VIDEO_ID_RST;
            frame_pts_reg  <= '0;
            frame_dts_reg  <= '0;
            busy_reg       <= 1'b0;
            step_reg       <= STEP_DATA;
            mod_cnt_reg    <= 4'd0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            mux_rate_reg   <= mux_rate_next;
            rate_bound_reg <= rate_bound_next;
            video_id_reg   <= video_id_next;
            frame_pts_reg  <= frame_pts_next;
            frame_dts_reg  <= frame_dts_next;
            busy_reg       <= busy_next;
            step_reg       <= step_next;
            mod_cnt_reg    <= mod_cnt_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
        key_reg     <= key_next;
        nalu_reg    <= nalu_next;
        data_reg    <= data_next;
        mod_sh_reg  <= mod_sh_next;
        mod_rem_reg <= mod_rem_next;
        m_tdata_reg <= m_tdata_next;
        m_tlast_reg <= m_tlast_next;
    end

    // ------------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------------
    a_item_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_acc && (s_opcode != OP_NONE)) |=> busy_reg)
        else $error("accepted item did not start the sequencer");

    a_step_range: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> (step_reg <= STEP_LAST))
        else $error("step counter ran past the program");

    a_last_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && end_bit && !s_acc) |=> (!busy_reg && m_tvalid && m_tlast))
        else $error("final byte did not end the item");

    a_mod_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_acc && (s_opcode == OP_FRAME)) |=> (mod_cnt_reg == 4'(MOD_DIGITS)))
        else $error("SCR extension not restarted on frame start");

endmodule

// ===== test/program_stream_packetizer_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// program_stream_packetizer_test
// Self-checking bench for the program stream packetizer. A directed table
// (reset-time PES headers, length wrap, field extremes, dropped items) runs
// first, then random frame / NAL / payload sequences under several register
// settings and idle patterns. Every output beat is checked against typed-in
// bytes or a local byte-level model of pack, system, stream map and PES headers.
// ----------------------------------------------------------------------------
module program_stream_packetizer_test;
    import psp_pkg::*;

    localparam int CYCLE_LIMIT = 400000;  // generous bound on the whole run
    localparam int HOLD_CYCLES = 400;     // long receiver hold-off
    localparam int PHASE_ITEMS = 70;      // counted items per random phase
    localparam int DRAIN_GAP   = 8;       // idle cycles before register writes

    // One input item, unpacked
    typedef struct {
        op_t         op;
        logic [32:0] pts;
        logic [32:0] dts;
        logic        key;
        logic [15:0] nal_len;
        logic [7:0]  payload;
    } ps_item_t;

    // Directed row: n_fixed < 0 means the model supplies the bytes
    typedef struct {
        ps_item_t     it;
        int           n_fixed;
        logic [151:0] fixed;
    } dir_row_t;

    typedef struct {
        logic [7:0] data;
        logic       last;
    } stream_beat_t;

    // ------------------------------------------------------------------------
    // DUT hookup
    // ------------------------------------------------------------------------
    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [95:0] s_tdata;   // pts[32:0], dts[65:33], nalu_length[81:66],
                            // data_byte[89:82], zero fill
    logic [2:0]  s_tuser;   // opcode[1:0], is_key_frame[2]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;   // out_byte[7:0]
    logic        m_tlast;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [21:0] cfg_data;

    program_stream_packetizer uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 12 ns period
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------------
    stream_beat_t pending_bytes[$];   // bytes the block still owes us
    dir_row_t     dir_rows[$];

    // local copy of registers and latched times
    logic [21:0] mux_rate_q   = 22'd255;
    logic [21:0] rate_bound_q = 22'd50000;
    logic [7:0]  video_id_q   = 8'd224;
    logic [32:0] cur_pts      = '0;
    logic [32:0] cur_dts      = '0;

    int   mismatches  = 0;
    int   beats_seen  = 0;
    int   items_sent  = 0;
    int   cycle_count = 0;
    int   snd_idle    = 11;     // percent of cycles the sender sits out
    int   rcv_idle    = 72;     // same for the receiver
    logic stall_go    = 1'b0;
    logic stall_on;

    // ------------------------------------------------------------------------
    // Reference byte stream
    // ------------------------------------------------------------------------

    // 33-bit stamp with marker bits, 4-bit prefix in front
    function automatic logic [39:0] time_field(input logic [3:0] prefix,
                                               input logic [32:0] t);
        return {prefix, t[32:30], 1'b1, t[29:15], 1'b1, t[14:0], 1'b1};
    endfunction

    // push the n low bytes of v, most significant first
    function automatic void queue_bytes(input logic [191:0] v, input int n);
        for (int k = n - 1; k >= 0; k--)
            pending_bytes.push_back('{v[8*k +: 8], 1'b0});
    endfunction

    function automatic void build_stream_bytes(input ps_item_t it);
        logic [111:0] pack;
        logic [143:0] sys;
        logic [191:0] smap;
        logic [151:0] pes;
        logic [8:0]   scr_ext;
        logic [15:0]  pes_len;
        case (it.op)
            OP_FRAME: begin
                cur_pts = it.pts;
                cur_dts = it.dts;
                scr_ext = 9'(cur_pts % 100);
                pack = {32'h000001BA, 2'b01, cur_pts[32:30], 1'b1, cur_pts[29:15],
                        1'b1, cur_pts[14:0], 1'b1, scr_ext, 1'b1, mux_rate_q,
                        2'b11, 5'h1F, 3'b000};
                queue_bytes(192'(pack), 14);
                if (it.key) begin
                    sys = {32'h000001BB, 16'd12, 1'b1, rate_bound_q, 1'b1, 6'd1,
                           1'b0, 4'b1111, 5'd1, 1'b0, 7'h7F,
                           8'hC0, 2'b11, 1'b0, 13'd512,
                           8'hE0, 2'b11, 1'b1, 13'd2048};
                    smap = {24'h000001, 8'hBC, 16'd18, 1'b1, 2'b11, 5'd0, 7'h7F,
                            1'b1, 16'd0, 16'd8, 8'h90, 8'hC0, 16'd0, 8'h1B,
                            8'hE0, 16'd0, 8'h45, 8'hBD, 8'hDC, 8'hF4};
                    queue_bytes(192'(sys), 18);
                    queue_bytes(smap, 24);
                end
            end
            OP_NAL: begin
                pes_len = it.nal_len + 16'd13;   // wraps by design
                pes = {24'h000001, video_id_q, pes_len, 2'b10, 6'd0, 2'b11, 6'd0,
                       8'd10, time_field(4'd3, cur_pts), time_field(4'd1, cur_dts)};
                queue_bytes(192'(pes), 19);
            end
            OP_BYTE: queue_bytes(192'(it.payload), 1);
            default: ;   // unused code: dropped
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic ps_item_t mk(input op_t op, input logic [32:0] pts,
                                    input logic [32:0] dts, input logic key,
                                    input logic [15:0] len, input logic [7:0] b);
        ps_item_t it;
        it.op      = op;
        it.pts     = pts;
        it.dts     = dts;
        it.key     = key;
        it.nal_len = len;
        it.payload = b;
        return it;
    endfunction

    // extremes now and then, full-range otherwise
    function automatic logic [32:0] rand33();
        logic [63:0] r;
        r = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return r[32:0];
        endcase
    endfunction

    function automatic ps_item_t rand_item(input op_t op);
        ps_item_t it;
        it = mk(op, rand33(), rand33(), 1'($urandom), 16'($urandom), 8'($urandom));
        case ($urandom_range(0, 9))
            0: it.nal_len = 16'h0000;
            1: it.nal_len = 16'hFFFF;
            2: it.nal_len = 16'd65522 + 16'($urandom_range(0, 13));  // around the wrap
            default: ;
        endcase
        return it;
    endfunction

    // Offer one item, wait for its beat, then queue what it should produce.
    // Called at a rising edge; leaves s_tvalid high so back-to-back items
    // never lower and raise it in the same step.
    task automatic issue(input ps_item_t it, input int n_fixed,
                         input logic [151:0] fixed);
        logic took;
        int   n0;
        while ($urandom_range(0, 99) < snd_idle) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, it.payload, it.nal_len, it.dts, it.pts};
        s_tuser  <= {it.key, it.op};
        do begin
            @(negedge aclk);
            took = s_tready;
            @(posedge aclk);
        end while (!took);
        n0 = pending_bytes.size();
        if (n_fixed < 0)
            build_stream_bytes(it);
        else
            queue_bytes(192'(fixed), n_fixed);
        if (pending_bytes.size() > n0)
            pending_bytes[pending_bytes.size() - 1].last = 1'b1;
        if (it.op != OP_NONE)
            items_sent++;
    endtask

    // Well-formed frame: frame start, a few NAL units with payload bytes.
    // A small share is noise: stray items of any kind, the unused code too.
    task automatic send_random_group();
        ps_item_t it;
        int       nals;
        if ($urandom_range(0, 99) < 8) begin
            issue(rand_item(op_t'($urandom_range(0, 3))), -1, '0);
        end else begin
            issue(rand_item(OP_FRAME), -1, '0);
            nals = $urandom_range(1, 3);
            repeat (nals) begin
                issue(rand_item(OP_NAL), -1, '0);
                repeat ($urandom_range(0, 6)) issue(rand_item(OP_BYTE), -1, '0);
            end
        end
    endtask

    // Stop offering, let every owed byte come out, then give a dropped item
    // time to leave the pipe before touching registers.
    task automatic drain_stream();
        s_tvalid <= 1'b0;
        while (pending_bytes.size() != 0) @(posedge aclk);
        repeat (DRAIN_GAP) @(posedge aclk);
    endtask

    // Write all three registers back to back; only legal while idle.
    task automatic load_regs(input logic [21:0] mr, input logic [21:0] rb,
                             input logic [7:0] vid);
        logic [1:0]  idx [3];
        logic [21:0] val [3];
        logic        took;
        idx[0] = CFG_MUX_RATE;   val[0] = mr;
        idx[1] = CFG_RATE_BOUND; val[1] = rb;
        idx[2] = CFG_VIDEO_ID;   val[2] = {14'd0, vid};
        for (int i = 0; i < 3; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            do begin
                @(negedge aclk);
                took = cfg_ready;
                @(posedge aclk);
            end while (!took);
        end
        cfg_valid    <= 1'b0;
        mux_rate_q   = mr;
        rate_bound_q = rb;
        video_id_q   = vid;
    endtask

    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= 40)
            $display("%0t ns: mismatch: %s", $realtime, what);
    endtask

    // ------------------------------------------------------------------------
    // Receiver: random ready, forced low during the hold-off
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= !stall_on && ($urandom_range(0, 99) >= rcv_idle);
        end
    end

    // Long hold-off, counted here; the sender keeps pushing meanwhile so the
    // block backs up and drops s_tready.
    initial begin
        stall_on = 1'b0;
        wait (stall_go);
        @(posedge aclk);
        stall_on <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        stall_on <= 1'b0;
    end

    // ------------------------------------------------------------------------
    // Output check. Sampled mid-cycle: values are settled and the beat
    // completes on the next rising edge.
    // ------------------------------------------------------------------------
    always @(negedge aclk) begin
        stream_beat_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_bytes.size() == 0) begin
                report_mismatch($sformatf("beat %0d: unexpected byte %02h",
                                          beats_seen, m_tdata));
            end else begin
                want = pending_bytes.pop_front();
                if (m_tdata !== want.data)
                    report_mismatch($sformatf("beat %0d: byte %02h, wanted %02h",
                                              beats_seen, m_tdata, want.data));
                if (m_tlast !== want.last)
                    report_mismatch($sformatf("beat %0d: tlast %b, wanted %b",
                                              beats_seen, m_tlast, want.last));
            end
            beats_seen++;
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_MUX_RATE;
        cfg_data  = '0;

        // Directed rows. The first ones run on reset times and reset
        // registers, so their bytes are typed in.
        // NAL start before any frame: zero stamps, stream id E0, length 13
        dir_rows.push_back('{mk(OP_NAL, '0, '0, 1'b0, 16'h0000, 8'h00), 19,
                             152'h000001E0_000D80C0_0A310001_00011100_010001});
        // length wrap: FFFF + 13 -> 000C
        dir_rows.push_back('{mk(OP_NAL, '1, '1, 1'b1, 16'hFFFF, 8'hFF), 19,
                             152'h000001E0_000C80C0_0A310001_00011100_010001});
        dir_rows.push_back('{mk(OP_BYTE, '0, '0, 1'b0, 16'h0000, 8'h00), 1, 152'h00});
        dir_rows.push_back('{mk(OP_BYTE, '1, '1, 1'b1, 16'hFFFF, 8'hFF), 1, 152'hFF});
        // unused code is dropped, even with every field set
        dir_rows.push_back('{mk(OP_NONE, '1, '1, 1'b1, 16'hFFFF, 8'hFF), 0, '0});
        // model-checked rows
        dir_rows.push_back('{mk(OP_FRAME, '0, '0, 1'b0, 16'h0000, 8'h00), -1, '0});
        dir_rows.push_back('{mk(OP_NAL, '0, '0, 1'b0, 16'h0001, 8'h00), -1, '0});
        dir_rows.push_back('{mk(OP_FRAME, '1, '1, 1'b1, 16'hFFFF, 8'hFF), -1, '0});
        dir_rows.push_back('{mk(OP_NAL, '0, '0, 1'b0, 16'd65522, 8'h00), -1, '0});
        dir_rows.push_back('{mk(OP_NAL, '0, '0, 1'b0, 16'd65523, 8'h00), -1, '0});
        dir_rows.push_back('{mk(OP_BYTE, '0, '0, 1'b0, 16'h0000, 8'hA5), -1, '0});
        dir_rows.push_back('{mk(OP_FRAME, 33'd99, 33'd1, 1'b1, 16'h0, 8'h0), -1, '0});
        dir_rows.push_back('{mk(OP_NAL, '0, '0, 1'b0, 16'h8000, 8'h00), -1, '0});
        dir_rows.push_back('{mk(OP_FRAME, 33'd100, 33'd0, 1'b0, 16'h0, 8'h0), -1, '0});
        dir_rows.push_back('{mk(OP_FRAME, 33'h155555555, 33'h0AAAAAAAA, 1'b1,
                                16'h5555, 8'h55), -1, '0});
        dir_rows.push_back('{mk(OP_NAL, '0, '0, 1'b0, 16'hAAAA, 8'hAA), -1, '0});
        dir_rows.push_back('{mk(OP_NONE, '0, '0, 1'b0, 16'h0000, 8'h00), -1, '0});
        dir_rows.push_back('{mk(OP_FRAME, 33'h100000000, 33'h0FFFFFFFF, 1'b0,
                                16'h0, 8'h0), -1, '0});
        dir_rows.push_back('{mk(OP_NAL, '0, '0, 1'b0, 16'h1234, 8'h00), -1, '0});
        dir_rows.push_back('{mk(OP_BYTE, '0, '0, 1'b0, 16'h0000, 8'h5A), -1, '0});

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_rows[i])
            issue(dir_rows[i].it, dir_rows[i].n_fixed, dir_rows[i].fixed);

        // Random phases: two each of sender-light, receiver-light and
        // no-idle traffic, with a different register setting per phase.
        for (int p = 0; p < 6; p++) begin
            drain_stream();
            case (p)
                0: load_regs(22'd0, 22'd0, 8'h00);
                1: load_regs(22'h3FFFFF, 22'h3FFFFF, 8'hFF);
                2: load_regs(22'($urandom), 22'($urandom), 8'($urandom));
                3: load_regs(22'd255, 22'd50000, 8'd224);
                4: load_regs(22'h3FFFFF, 22'd0, 8'hBD);
                default: load_regs(22'($urandom), 22'($urandom), 8'($urandom));
            endcase
            snd_idle = (p < 2) ? 11 : (p < 4) ? 72 : 0;
            rcv_idle <= (p < 2) ? 72 : (p < 4) ? 11 : 0;
            if (p == 4)
                stall_go <= 1'b1;
            items_sent = 0;
            while (items_sent < PHASE_ITEMS)
                send_random_group();
        end

        drain_stream();
        repeat (16) @(posedge aclk);
        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
